[rtl/core/itrt_pkg.sv]
// itrt_pkg: shared types, constants and the digit-to-character function
// for the radix text converter. Depends on nothing; imported by every module.
`default_nettype none

package itrt_pkg;

    // width of one digit value, enough for 0..35
    localparam int unsigned DIGIT_W = 6;

    // radix register
    localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [DIGIT_W-1:0] MIN_RADIX   = 6'd2;
    localparam logic [DIGIT_W-1:0] MAX_RADIX   = 6'd36;
    localparam logic [DIGIT_W-1:0] MAX_DIGIT   = 6'd35;

    // register index of the radix register
    localparam logic RADIX_INDEX = 1'b0;

    // characters
    localparam logic [7:0] MINUS_CHAR  = 8'h2D;
    localparam logic [7:0] NUL_CHAR    = 8'h00;
    localparam logic [7:0] ZERO_CHAR   = 8'h30;
    localparam logic [7:0] LETTER_BASE = 8'h57;  // 'a' minus ten

    // status from the serial divider
    typedef struct packed {
        logic done;      // one-cycle pulse, results valid
        logic quo_zero;  // quotient is zero
    } itrt_div_status_t;

    // digit value to lowercase ascii
    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] c;
        c = (d > MAX_DIGIT) ? MAX_DIGIT : d;
        if (c < 6'd10)
            return ZERO_CHAR + {2'b00, c};
        else
            return LETTER_BASE + {2'b00, c};
    endfunction

endpackage

`default_nettype wire

[rtl/core/itrt_serial_div.sv]
// itrt_serial_div: bit-serial restoring divider, one quotient bit a cycle,
// dividing an unsigned word by a 6-bit radix. Depends on itrt_pkg.
`default_nettype none

module itrt_serial_div
    import itrt_pkg::*;
#(
    parameter int unsigned WIDTH = 32
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [WIDTH-1:0]    dividend,
    input  wire logic [DIGIT_W-1:0]  radix,
    output itrt_div_status_t         status,
    output logic [WIDTH-1:0]         quotient,
    output logic [DIGIT_W-1:0]       remainder
);

    localparam int unsigned CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [WIDTH-1:0]   quo_reg, quo_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]   bit_cnt_reg;
    logic               running_reg;
    logic               done_reg;

    logic [DIGIT_W:0]   trial;
    logic [DIGIT_W:0]   diff;
    logic               ge;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, quo_reg[WIDTH-1]};
        diff     = trial - {1'b0, radix};
        ge       = (trial >= {1'b0, radix});
        rem_next = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
        quo_next = {quo_reg[WIDTH-2:0], ge};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg <= '0;
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            // done pulses for one cycle after the last step
            done_reg <= !start && running_reg && (bit_cnt_reg == CNT_W'(WIDTH - 1));
            if (start)
            begin
                bit_cnt_reg <= '0;
                running_reg <= 1'b1;
            end
            else if (running_reg)
            begin
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == CNT_W'(WIDTH - 1))
                    running_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (running_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign status.done     = done_reg;
    assign status.quo_zero = (quo_reg == '0);
    assign quotient        = quo_reg;
    assign remainder       = rem_reg;

endmodule

`default_nettype wire

[rtl/core/integer_to_radix_text.sv]
// integer_to_radix_text: top level, signed integer to ascii text in radix 2..36.
// Depends on itrt_pkg and itrt_serial_div.
`default_nettype none
//
// Usage
//   Input channel (in_valid, in_stall, value) carries one signed integer per
//   beat. Output channel (out_valid, out_stall, text_char, is_last) carries one
//   ascii character per beat: an optional '-', the digits most significant
//   first, then a NUL beat with is_last set. A radix outside 2..36 gives the
//   NUL beat alone. The radix register sits at byte address 0 of the apb port.
//   One value is converted at a time; in_stall is high from acceptance until
//   the NUL beat has been loaded into the output register.
//   Flow: each digit comes from one full run of the bit-serial divider, then
//   each digit character passes through the digit memory read and the output
//   register; the sign and the NUL go straight to the output register.
//   A stalled receiver holds the current beat in the output register and
//   pauses character emission; nothing is dropped.
//   Reset sets the radix to 10 and returns the block to idle with no beat
//   pending. The digit memory needs no clearing.
//
module integer_to_radix_text
    import itrt_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // apb configuration port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // input channel
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [VALUE_WIDTH-1:0] value,
    // output channel
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [7:0]                  text_char,
    output logic                        is_last
);

    localparam int unsigned ADDR_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int unsigned CNT_W  = $clog2(VALUE_WIDTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVIDE,
        S_SIGN,
        S_READ,
        S_DIGIT,
        S_NUL
    } state_t;

    state_t             state_reg;
    logic [DIGIT_W-1:0] radix_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               neg_reg;
    logic               out_valid_reg;
    logic [7:0]         text_char_reg;
    logic               is_last_reg;

    logic [DIGIT_W-1:0] digit_mem [VALUE_WIDTH];
    logic [DIGIT_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic               wr_en;

    logic                   in_accept;
    logic                   radix_ok;
    logic                   slot_free;
    logic                   out_load;
    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic [VALUE_WIDTH-1:0] magnitude;
    logic [VALUE_WIDTH-1:0] div_quotient;
    logic [DIGIT_W-1:0]     div_remainder;
    itrt_div_status_t       div_status;
    logic                   cfg_write;
    logic [CNT_W-1:0]       count_dec;

    // apb register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == RADIX_INDEX);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == RADIX_INDEX)
            prdata = {{(32 - DIGIT_W){1'b0}}, radix_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= RADIX_RESET;
        else if (cfg_write)
            radix_reg <= pwdata[DIGIT_W-1:0];
    end

    // handshake and divider control
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign radix_ok  = (radix_reg >= MIN_RADIX) && (radix_reg <= MAX_RADIX);
    assign slot_free = !out_valid_reg || !out_stall;
    assign out_load  = slot_free
                    && (state_reg == S_SIGN || state_reg == S_DIGIT || state_reg == S_NUL);
    assign magnitude = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;

    assign div_start    = (in_accept && radix_ok)
                       || (state_reg == S_DIVIDE && div_status.done && !div_status.quo_zero);
    assign div_dividend = (state_reg == S_IDLE) ? magnitude : div_quotient;

    itrt_serial_div #(
        .WIDTH     (VALUE_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .radix     (radix_reg),
        .status    (div_status),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // digit memory, least significant digit at address 0
    assign wr_en     = (state_reg == S_DIVIDE) && div_status.done;
    assign wr_addr   = count_reg[ADDR_W-1:0];
    assign count_dec = count_reg - 1'b1;
    assign rd_addr   = count_dec[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            digit_mem[wr_addr] <= div_remainder;
        rd_data_reg <= digit_mem[rd_addr];
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            text_char_reg <= NUL_CHAR;
            is_last_reg   <= 1'b0;
        end
        else
        begin
            // beat taken and nothing new loaded
            if (out_valid_reg && !out_stall && !out_load)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        count_reg <= '0;
                        if (radix_ok)
                        begin
                            neg_reg   <= value[VALUE_WIDTH-1];
                            state_reg <= S_DIVIDE;
                        end
                        else
                        begin
                            neg_reg   <= 1'b0;
                            state_reg <= S_NUL;
                        end
                    end
                end
                S_DIVIDE:
                begin
                    if (div_status.done)
                    begin
                        count_reg <= count_reg + 1'b1;
                        if (div_status.quo_zero)
                            state_reg <= neg_reg ? S_SIGN : S_READ;
                    end
                end
                S_SIGN:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        text_char_reg <= MINUS_CHAR;
                        is_last_reg   <= 1'b0;
                        state_reg     <= S_READ;
                    end
                end
                S_READ:
                begin
                    // memory read of the top remaining digit lands this edge
                    state_reg <= S_DIGIT;
                end
                S_DIGIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        text_char_reg <= digit_char(rd_data_reg);
                        is_last_reg   <= 1'b0;
                        count_reg     <= count_dec;
                        state_reg     <= (count_reg == CNT_W'(1)) ? S_NUL : S_READ;
                    end
                end
                S_NUL:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        text_char_reg <= NUL_CHAR;
                        is_last_reg   <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign text_char = text_char_reg;
    assign is_last   = is_last_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(VALUE_WIDTH))
        else $error("digit count beyond value width");

    a_digit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIGIT) |-> (count_reg != '0))
        else $error("digit emission with no stored digit");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == S_DIVIDE))
        else $error("divider finished outside the divide phase");

    a_minus_negative: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_last && text_char == MINUS_CHAR) |-> neg_reg)
        else $error("minus beat for a non-negative value");

    a_nul_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NUL && slot_free) |=> (out_valid && is_last && state_reg == S_IDLE))
        else $error("terminator beat not loaded on leaving the item");

endmodule

`default_nettype wire

[dv/integer_to_radix_text_checker.sv]
`timescale 1ns / 1ps
// integer_to_radix_text_checker: watches the register port and both channels,
// predicts the text of every accepted value and compares each output beat.
// Depends on itrt_pkg.

module integer_to_radix_text_checker
    import itrt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic [31:0] prdata,
    input  wire logic        pready,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [31:0] value,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [7:0]  text_char,
    input  wire logic        is_last,
    input  wire logic        wrap_up,
    output int unsigned      backlog,
    output int unsigned      chars_checked,
    output int unsigned      fail_count
);

    localparam logic [2:0] RADIX_ADDR = {RADIX_INDEX, 2'b00};
    localparam logic [7:0] LOWER_A    = "a";
    localparam int unsigned PRINT_CAP = 60;

    typedef struct packed {
        logic [7:0] glyph;
        logic       terminal;
    } text_beat_t;

    text_beat_t       expected_text[$];
    text_beat_t       oldest;
    logic [DIGIT_W-1:0] radix_shadow;
    logic             wrapped;

    // one line per mismatch, printing capped but counting not
    task automatic report_mismatch(input string what);
        if (fail_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    // digit value to its lowercase character
    function automatic logic [7:0] glyph_of(input logic [DIGIT_W-1:0] d);
        if (d < 6'd10)
            return ZERO_CHAR + 8'(d);
        return LOWER_A + 8'(d - 6'd10);
    endfunction

    // expected characters of one value in the current radix
    task automatic predict_text(input logic [31:0] v);
        logic [31:0]        mag;
        logic [DIGIT_W-1:0] digits [32];
        int                 count;
        int                 i;
        logic               negative;
        if (radix_shadow < MIN_RADIX || radix_shadow > MAX_RADIX)
        begin
            expected_text.push_back('{glyph: NUL_CHAR, terminal: 1'b1});
            return;
        end
        negative = v[31];
        mag = negative ? -v : v;
        count = 0;
        // least significant digit first, magnitude taken unsigned
        do
        begin
            digits[count] = DIGIT_W'(mag % radix_shadow);
            mag = mag / radix_shadow;
            count++;
        end
        while (mag != 0);
        if (negative)
            expected_text.push_back('{glyph: MINUS_CHAR, terminal: 1'b0});
        for (i = count - 1; i >= 0; i--)
            expected_text.push_back('{glyph: glyph_of(digits[i]), terminal: 1'b0});
        expected_text.push_back('{glyph: NUL_CHAR, terminal: 1'b1});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_text.delete();
            radix_shadow  = RADIX_RESET;
            wrapped       = 1'b0;
            chars_checked = 0;
            fail_count    = 0;
            backlog      <= 0;
        end
        else
        begin
            // register port: track writes, check read-back
            if (psel && penable && pready && paddr == RADIX_ADDR)
            begin
                if (pwrite)
                    radix_shadow = pwdata[DIGIT_W-1:0];
                else if (prdata[DIGIT_W-1:0] !== radix_shadow)
                    report_mismatch($sformatf("radix read back %0d, expected %0d",
                                              prdata[DIGIT_W-1:0], radix_shadow));
            end
            // output beat against the oldest expectation
            if (out_valid && !out_stall)
            begin
                chars_checked++;
                if (expected_text.size() == 0)
                    report_mismatch($sformatf("unexpected beat, char 0x%02h last %b",
                                              text_char, is_last));
                else
                begin
                    oldest = expected_text.pop_front();
                    if (text_char !== oldest.glyph)
                        report_mismatch($sformatf("text_char 0x%02h, expected 0x%02h",
                                                  text_char, oldest.glyph));
                    if (is_last !== oldest.terminal)
                        report_mismatch($sformatf("is_last %b, expected %b on char 0x%02h",
                                                  is_last, oldest.terminal, oldest.glyph));
                end
            end
            // input beat
            if (in_valid && !in_stall)
                predict_text(value);
            // leftovers at the end of the run
            if (wrap_up && !wrapped)
            begin
                wrapped = 1'b1;
                if (expected_text.size() != 0)
                    report_mismatch($sformatf("%0d expected characters never arrived",
                                              expected_text.size()));
            end
            backlog <= expected_text.size();
        end
    end

endmodule

[dv/integer_to_radix_text_test.sv]
`timescale 1ns / 1ps
// integer_to_radix_text_test: stimulus and verdict for the radix text converter.
// Depends on itrt_pkg, integer_to_radix_text and integer_to_radix_text_checker.

module integer_to_radix_text_test;
    import itrt_pkg::*;

    localparam int unsigned VALUE_WIDTH  = 32;
    localparam int unsigned RANDOM_ITEMS = 320;
    localparam int unsigned CALM_FROM    = 270;
    localparam logic [2:0]  RADIX_ADDR   = {RADIX_INDEX, 2'b00};
    localparam logic [31:0] MOST_NEG     = 32'h8000_0000;
    localparam logic [31:0] MOST_POS     = 32'h7FFF_FFFF;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] value;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  text_char;
    logic        is_last;
    logic        wrap_up;
    logic        calm;
    int unsigned backlog;
    int unsigned chars_checked;
    int unsigned fail_count;
    int unsigned values_sent;
    int unsigned radix_writes;
    int unsigned stall_left;

    integer_to_radix_text #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .text_char (text_char),
        .is_last   (is_last)
    );

    integer_to_radix_text_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .text_char     (text_char),
        .is_last       (is_last),
        .wrap_up       (wrap_up),
        .backlog       (backlog),
        .chars_checked (chars_checked),
        .fail_count    (fail_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard limit on run time
    initial
    begin
        #30_000_000;
        $display("Verification failed");
        $finish;
    end

    // receiver stalls in bursts, free stretches in between, none when calm
    always @(posedge clk)
    begin
        if (calm || !rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
            stall_left--;
        else if ($urandom_range(0, 2) == 0)
        begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 6);
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left = $urandom_range(0, 30);
        end
    end

    function automatic logic invalid_radix(input logic [DIGIT_W-1:0] r);
        return r < MIN_RADIX || r > MAX_RADIX;
    endfunction

    // one input beat, with an optional idle burst ahead of it
    task automatic pass_value(input logic [31:0] v);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do @(posedge clk); while (in_stall);
        values_sent++;
    endtask

    // register write followed by a read-back
    task automatic set_radix(input logic [DIGIT_W-1:0] r);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RADIX_ADDR;
        pwdata  <= {26'd0, r};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        radix_writes++;
    endtask

    // drop valid and wait for every expected beat, then a short pause
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (backlog != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [DIGIT_W-1:0] pick_radix();
        case ($urandom_range(0, 9))
            0: return MIN_RADIX;
            1: return MAX_RADIX;
            2:
            begin
                if ($urandom_range(0, 1) == 0)
                    return DIGIT_W'($urandom_range(0, 1));
                return DIGIT_W'($urandom_range(37, 63));
            end
            default: return DIGIT_W'($urandom_range(MIN_RADIX, MAX_RADIX));
        endcase
    endfunction

    // values spread over magnitudes, extremes and digit-count boundaries
    function automatic logic [31:0] pick_value(input logic [DIGIT_W-1:0] r);
        logic [31:0] p;
        logic [31:0] v;
        int unsigned base;
        base = invalid_radix(r) ? 10 : r;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5: v = $urandom_range(0, 2 * base * base) - base * base;
            6:
            begin
                case ($urandom_range(0, 3))
                    0: v = MOST_NEG;
                    1: v = MOST_POS;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            7:
            begin
                p = 1;
                repeat ($urandom_range(1, 31))
                    if (p <= MOST_POS / base)
                        p = p * base;
                v = p - $urandom_range(0, 1);
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            default:
            begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
        endcase
        return v;
    endfunction

    // stimulus and verdict
    initial
    begin : stimulus
        logic [DIGIT_W-1:0] r;
        int unsigned        n;
        int unsigned        random_done;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        value        = '0;
        out_stall    = 1'b0;
        wrap_up      = 1'b0;
        calm         = 1'b0;
        values_sent  = 0;
        radix_writes = 0;
        stall_left   = 0;
        random_done  = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: decimal from reset, extremes and zero
        pass_value('0);
        pass_value(32'd1);
        pass_value('1);
        pass_value(MOST_POS);
        pass_value(MOST_NEG);
        pass_value(32'd10);
        pass_value(-32'sd10);
        settle();
        // widest radix, letters up to 'z'
        set_radix(MAX_RADIX);
        pass_value(32'd35);
        pass_value(32'd36);
        pass_value(-32'sd36);
        pass_value(MOST_POS);
        pass_value(MOST_NEG);
        settle();
        // binary gives the longest text
        set_radix(MIN_RADIX);
        pass_value(MOST_POS);
        pass_value(MOST_NEG);
        pass_value('1);
        pass_value('0);
        settle();
        set_radix(6'd16);
        pass_value(32'h89AB_CDEF);
        settle();
        // radix out of range: terminator only
        set_radix(6'd0);
        pass_value($urandom);
        settle();
        set_radix(6'd1);
        pass_value($urandom);
        settle();
        set_radix(6'd37);
        pass_value($urandom);
        settle();
        set_radix(6'd63);
        pass_value($urandom);
        settle();

        // random phases, one radix per phase
        while (random_done < RANDOM_ITEMS)
        begin
            r = pick_radix();
            set_radix(r);
            n = invalid_radix(r) ? $urandom_range(1, 3) : $urandom_range(6, 30);
            repeat (n)
            begin
                if (random_done >= CALM_FROM)
                    calm <= 1'b1;
                pass_value(pick_value(r));
                random_done++;
            end
            settle();
        end

        repeat (40) @(posedge clk);
        wrap_up <= 1'b1;
        repeat (2) @(posedge clk);
        $display("converted %0d values under %0d radix writes, %0d characters compared",
                 values_sent, radix_writes, chars_checked);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
